/* design/ref_pkg.sv */
// shared types and constants for the rectangle edge fit block
// no dependencies
`timescale 1ns / 1ps
package ref_pkg;
    localparam int COORD_W = 16;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_OVF = 2'd3;
    localparam logic [1:0] SIDE_HX = 2'd0;
    localparam logic [1:0] SIDE_LY = 2'd1;
    localparam logic [1:0] SIDE_LX = 2'd2;
    localparam logic [1:0] SIDE_HY = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_point;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [COORD_W-1:0] x_low;
        logic signed [COORD_W-1:0] x_high;
        logic signed [COORD_W-1:0] y_low;
        logic signed [COORD_W-1:0] y_high;
        logic                      box_only;
    } t_result;
endpackage

/* design/rectangle_edge_fit_core.sv */
// top level of the rectangle edge fit block
// depends on ref_pkg, ref_fifo, ref_back
`timescale 1ns / 1ps
// Points enter through a four-entry request queue and load into the store one
// per cycle while the block is loading. After the last point of a set of more
// than four points the block runs the side pass over the stored points, then up
// to four serial floor divisions, and holds the result until taken. Status
// overflow reports points dropped beyond MAX_POINTS.
module rectangle_edge_fit_core
    import ref_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic        i_last_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_x_low_edge,
    output logic [15:0] o_x_high_edge,
    output logic [15:0] o_y_low_edge,
    output logic [15:0] o_y_high_edge,
    output logic        o_box_only
);
    t_point  in_pt, q_pt;
    logic    q_valid, q_stall;
    t_result res;

    assign in_pt.x = i_point_x;
    assign in_pt.y = i_point_y;
    assign in_pt.last = i_last_point;

    ref_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(in_pt),
        .o_valid(q_valid), .i_stall(q_stall), .o_data(q_pt)
    );

    ref_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_stall(q_stall), .i_pt(q_pt),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    assign o_status = res.status;
    assign o_x_low_edge = res.x_low;
    assign o_x_high_edge = res.x_high;
    assign o_y_low_edge = res.y_low;
    assign o_y_high_edge = res.y_high;
    assign o_box_only = res.box_only;
endmodule

/* design/ref_fifo.sv */
// short request queue between the front and back parts
// depends on ref_pkg
`timescale 1ns / 1ps
module ref_fifo
    import ref_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_point i_data,
    output logic   o_valid,
    input  logic   i_stall,
    output t_point o_data
);
    t_point     r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_stall = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
    end
endmodule

/* design/ref_div.sv */
// iterative signed floor divider: 26 bit sum by unsigned count
// depends on ref_pkg
`timescale 1ns / 1ps
module ref_div
    import ref_pkg::*;
#(
    parameter int CW = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [CW+15-1:0]   i_sum,
    input  logic [CW-1:0]             i_cnt,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_quot
);
    localparam int SW = CW + 15;
    localparam int IW = $clog2(SW + 1);
    logic [SW-1:0] r_q;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_d;
    logic          r_neg, r_busy;
    logic [IW-1:0] r_i;
    logic [CW:0]   trial;
    logic [SW-1:0] mag, qf;

    assign trial = {r_rem[CW-1:0], r_q[SW-1]};
    assign mag = i_sum[SW-1] ? SW'(-i_sum) : SW'(i_sum);
    assign qf = r_neg ? ((r_rem != '0) ? ~r_q : SW'(-r_q)) : r_q;
    assign o_quot = qf[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q <= mag;
                r_rem <= '0;
                r_d <= i_cnt;
                r_neg <= i_sum[SW-1];
                r_i <= IW'(SW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_d}) begin
                    r_rem <= trial - {1'b0, r_d};
                    r_q <= {r_q[SW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q <= {r_q[SW-2:0], 1'b0};
                end
                r_i <= r_i - IW'(1);
                if (r_i == IW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* design/ref_back.sv */
// back part: point store, bounding box, side pass and edge averages
// depends on ref_pkg and ref_div
`timescale 1ns / 1ps
module ref_back
    import ref_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_point  i_pt,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = CW + 15;

    typedef enum logic [2:0] {S_LOAD, S_RD, S_PASS, S_DIV, S_WAIT, S_OUT} t_state;
    t_state r_st;

    logic signed [COORD_W-1:0] r_xs [MAX_POINTS];
    logic signed [COORD_W-1:0] r_ys [MAX_POINTS];
    logic [CW-1:0] r_cnt, r_idx;
    logic          r_ovf;
    logic signed [COORD_W-1:0] r_mnx, r_mxx, r_mny, r_mxy;
    logic signed [SW-1:0] r_sum [4];
    logic [CW-1:0] r_sc [4];
    logic signed [COORD_W-1:0] r_rx, r_ry;
    logic          r_rv;
    logic [1:0]    r_near, r_side;
    logic signed [COORD_W-1:0] r_edge [4];
    logic [1:0]    r_status;
    logic          r_box_only;

    logic acc;
    logic signed [COORD_W:0] w, h, lng, best, d [4];
    logic [1:0] sel;
    logic signed [COORD_W-1:0] dq;
    logic dstart, ddone;

    assign acc = i_valid && !o_stall && r_st == S_LOAD;
    assign o_stall = (r_st != S_LOAD);
    assign o_valid = (r_st == S_OUT);

    always_comb begin
        w = {r_mxx[15], r_mxx} - {r_mnx[15], r_mnx};
        h = {r_mxy[15], r_mxy} - {r_mny[15], r_mny};
        lng = (w > h) ? w : h;
        d[0] = {r_mxx[15], r_mxx} - {r_rx[15], r_rx};
        d[1] = {r_mny[15], r_mny} - {r_ry[15], r_ry};
        d[2] = {r_mnx[15], r_mnx} - {r_rx[15], r_rx};
        d[3] = {r_mxy[15], r_mxy} - {r_ry[15], r_ry};
        best = lng;
        sel = r_near;
        for (int s = 0; s < 4; s++) begin
            if (d[s] < 0) d[s] = -d[s];
            if (d[s] < best) begin
                best = d[s];
                sel = 2'(s);
            end
        end
    end

    assign dstart = (r_st == S_DIV);

    ref_div #(.CW(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dstart),
        .i_sum(r_sum[r_side]), .i_cnt(r_sc[r_side]),
        .o_done(ddone), .o_quot(dq)
    );

    always_ff @(posedge i_clk) begin
        if (acc && r_cnt < CW'(MAX_POINTS)) begin
            r_xs[r_cnt[AW-1:0]] <= i_pt.x;
            r_ys[r_cnt[AW-1:0]] <= i_pt.y;
        end
        r_rx <= r_xs[r_idx[AW-1:0]];
        r_ry <= r_ys[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_mnx <= '0; r_mxx <= '0; r_mny <= '0; r_mxy <= '0;
            r_rv <= 1'b0;
        end else begin
            unique case (r_st)
                S_LOAD: begin
                    if (acc) begin
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            r_cnt <= r_cnt + CW'(1);
                            if (r_cnt == '0 || i_pt.x < r_mnx) r_mnx <= i_pt.x;
                            if (r_cnt == '0 || i_pt.x > r_mxx) r_mxx <= i_pt.x;
                            if (r_cnt == '0 || i_pt.y < r_mny) r_mny <= i_pt.y;
                            if (r_cnt == '0 || i_pt.y > r_mxy) r_mxy <= i_pt.y;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_pt.last) begin
                            r_idx <= '0;
                            r_near <= SIDE_HX;
                            r_rv <= 1'b0;
                            for (int s = 0; s < 4; s++) begin
                                r_sum[s] <= '0;
                                r_sc[s] <= '0;
                                r_edge[s] <= '0;
                            end
                            r_st <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_box_only <= (r_cnt == CW'(4));
                    r_status <= (r_cnt < CW'(4)) ? ST_FEW : ST_OK;
                    if (r_cnt < CW'(4)) begin
                        r_st <= S_OUT;
                    end else if (r_cnt == CW'(4)) begin
                        r_edge[0] <= r_mxx; r_edge[1] <= r_mny;
                        r_edge[2] <= r_mnx; r_edge[3] <= r_mxy;
                        r_st <= S_OUT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_rv <= 1'b1;
                        r_st <= S_PASS;
                    end
                end
                S_PASS: begin
                    if (r_rv) begin
                        r_near <= sel;
                        r_sc[sel] <= r_sc[sel] + CW'(1);
                        if (sel == SIDE_HX || sel == SIDE_LX)
                            r_sum[sel] <= r_sum[sel] + SW'(r_rx);
                        else
                            r_sum[sel] <= r_sum[sel] + SW'(r_ry);
                    end
                    if (r_idx == r_cnt) begin
                        r_rv <= 1'b0;
                        if (!r_rv) begin
                            r_side <= SIDE_HX;
                            r_st <= S_DIV;
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_DIV: begin
                    if (r_sc[r_side] == '0) begin
                        r_status <= ST_EMPTY;
                        if (r_side == SIDE_HY) r_st <= S_OUT;
                        r_side <= r_side + 2'd1;
                    end else begin
                        r_st <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (ddone) begin
                        r_edge[r_side] <= dq;
                        r_side <= r_side + 2'd1;
                        r_st <= (r_side == SIDE_HY) ? S_OUT : S_DIV;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                        r_mnx <= '0; r_mxx <= '0; r_mny <= '0; r_mxy <= '0;
                        r_st <= S_LOAD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_res.status   = r_ovf ? ST_OVF : r_status;
        o_res.x_high   = r_edge[0];
        o_res.y_low    = r_edge[1];
        o_res.x_low    = r_edge[2];
        o_res.y_high   = r_edge[3];
        o_res.box_only = r_box_only;
    end
endmodule

/* sim/tb.sv */
// testbench for rectangle_edge_fit_core: drives point sets, predicts fits in a
// local model of the side pass and compares every result; depends on ref_pkg
`timescale 1ns / 1ps
module tb
    import ref_pkg::*;
();

    localparam int STORE_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic        known;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_point_x = '0;
    logic [15:0] i_point_y = '0;
    logic        i_last_point = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_x_low_edge;
    logic [15:0] o_x_high_edge;
    logic [15:0] o_y_low_edge;
    logic [15:0] o_y_high_edge;
    logic        o_box_only;

    rectangle_edge_fit_core u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // fit state
    int      pts_x[STORE_DEPTH];
    int      pts_y[STORE_DEPTH];
    int      n_stored;
    bit      dropped;
    int      bx_lo, bx_hi, by_lo, by_hi;
    t_result fits_due[$];
    bit      failed;
    int      idle_cycles;
    int      sender_idle_pct;
    int      sink_idle_pct;

    function automatic int floor_div(longint sum, int cnt);
        longint q;
        q = sum / cnt;
        if ((sum % cnt) != 0 && sum < 0) q -= 1;
        return int'(q);
    endfunction

    function automatic int absv(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void clear_set();
        n_stored = 0;
        dropped = 0;
        bx_lo = 0; bx_hi = 0; by_lo = 0; by_hi = 0;
    endfunction

    // returns 1 when a fit is due, in fit
    function automatic bit add_point(logic [15:0] xr, logic [15:0] yr, logic last,
                                     output t_result fit);
        int      px, py, longest, best, side;
        int      d[4];
        longint  sums[4];
        int      cnts[4];
        int      edges[4];
        logic [1:0] st;
        px = int'($signed(xr));
        py = int'($signed(yr));
        fit = '0;
        if (n_stored < STORE_DEPTH) begin
            pts_x[n_stored] = px;
            pts_y[n_stored] = py;
            if (n_stored == 0) begin
                bx_lo = px; bx_hi = px; by_lo = py; by_hi = py;
            end else begin
                if (px < bx_lo) bx_lo = px;
                if (px > bx_hi) bx_hi = px;
                if (py < by_lo) by_lo = py;
                if (py > by_hi) by_hi = py;
            end
            n_stored++;
        end else begin
            dropped = 1;
        end
        if (!last) return 0;
        st = ST_OK;
        edges = '{0, 0, 0, 0};
        if (n_stored < 4) begin
            st = ST_FEW;
        end else if (n_stored == 4) begin
            fit.box_only = 1'b1;
            edges = '{bx_hi, by_lo, bx_lo, by_hi};
        end else begin
            sums = '{0, 0, 0, 0};
            cnts = '{0, 0, 0, 0};
            longest = (bx_hi - bx_lo) > (by_hi - by_lo) ? bx_hi - bx_lo : by_hi - by_lo;
            side = SIDE_HX;
            for (int i = 0; i < n_stored; i++) begin
                d[SIDE_HX] = absv(bx_hi - pts_x[i]);
                d[SIDE_LY] = absv(by_lo - pts_y[i]);
                d[SIDE_LX] = absv(bx_lo - pts_x[i]);
                d[SIDE_HY] = absv(by_hi - pts_y[i]);
                best = longest;
                for (int s = 0; s < 4; s++) begin
                    if (d[s] < best) begin
                        best = d[s];
                        side = s;
                    end
                end
                sums[side] += (side == SIDE_HX || side == SIDE_LX) ? pts_x[i] : pts_y[i];
                cnts[side]++;
            end
            for (int s = 0; s < 4; s++) begin
                if (cnts[s] == 0) st = ST_EMPTY;
                else edges[s] = floor_div(sums[s], cnts[s]);
            end
        end
        if (dropped) st = ST_OVF;
        fit.status = st;
        fit.x_low = edges[SIDE_LX][15:0];
        fit.x_high = edges[SIDE_HX][15:0];
        fit.y_low = edges[SIDE_LY][15:0];
        fit.y_high = edges[SIDE_HY][15:0];
        clear_set();
        return 1;
    endfunction

    task automatic send_point(logic [15:0] xr, logic [15:0] yr, logic last);
        t_result fit;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_x <= xr;
        i_point_y <= yr;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (add_point(xr, yr, last, fit)) fits_due.push_back(fit);
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < sink_idle_pct);
            if (o_valid && !i_stall) begin
                got = '{o_status, o_x_low_edge, o_x_high_edge, o_y_low_edge,
                        o_y_high_edge, o_box_only};
                if (fits_due.size() == 0) begin
                    $display("%0t: unexpected fit %p", $time, got);
                    failed = 1;
                end else begin
                    want = fits_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: fit mismatch expected %p actual %p", $time, want, got);
                        failed = 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("rectangle_edge_fit_core verification failed");
            $finish;
        end
    end

    task automatic send_set(int n, int spread, bit degenerate);
        int cx, cy, w, h, k;
        logic [15:0] xr, yr;
        cx = $urandom_range(65535) - 32768;
        cy = $urandom_range(65535) - 32768;
        w = $urandom_range(spread);
        h = $urandom_range(spread);
        for (int i = 0; i < n; i++) begin
            if (degenerate) begin
                xr = $urandom; yr = $urandom;
            end else begin
                k = $urandom_range(3);
                xr = 16'(k == 0 ? cx + w : k == 2 ? cx - w : cx + $urandom_range(2*w) - w);
                yr = 16'(k == 1 ? cy - h : k == 3 ? cy + h : cy + $urandom_range(2*h) - h);
                xr = xr + 16'($urandom_range(4)) - 16'd2;
                yr = yr + 16'($urandom_range(4)) - 16'd2;
            end
            send_point(xr, yr, i == n - 1);
        end
    endtask

    t_row rows[$];
    int sent;

    function automatic t_row mk(int x, int y, bit last, bit known, t_result r);
        t_row t;
        t.x = 16'(x); t.y = 16'(y); t.last = last; t.known = known; t.res = r;
        return t;
    endfunction

    initial begin
        failed = 0;
        idle_cycles = 0;
        sender_idle_pct = 17;
        sink_idle_pct = 17;
        clear_set();
        // too few points
        rows.push_back(mk(5, 5, 1, 1, '{ST_FEW, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}));
        rows.push_back(mk(-32768, 32767, 0, 0, '0));
        rows.push_back(mk(32767, -32768, 0, 0, '0));
        rows.push_back(mk(-1, -1, 1, 1, '{ST_FEW, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}));
        // plain box at the extremes
        rows.push_back(mk(-32768, -32768, 0, 0, '0));
        rows.push_back(mk(32767, 32767, 0, 0, '0));
        rows.push_back(mk(0, 0, 0, 0, '0));
        rows.push_back(mk(100, -100, 1, 1,
                          '{ST_OK, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1}));
        // five points on a square, all sides used
        rows.push_back(mk(0, 0, 0, 0, '0));
        rows.push_back(mk(64, 0, 0, 0, '0));
        rows.push_back(mk(64, 64, 0, 0, '0));
        rows.push_back(mk(0, 64, 0, 0, '0));
        rows.push_back(mk(-3, 31, 1, 0, '0));
        // all points equal: no side nearer than the longer side, empty sides
        for (int i = 0; i < 5; i++)
            rows.push_back(mk(7, 7, i == 4, 1,
                              '{ST_EMPTY, 16'd0, 16'd7, 16'd0, 16'd0, 1'b0}));
        for (int i = 0; i < 6; i++)
            rows.push_back(mk(-i * 17, i * 23 - 50, i == 5, 0, '0));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r]) begin
            if (rows[r].known && rows[r].last) begin
                send_point(rows[r].x, rows[r].y, 1'b1);
                fits_due[fits_due.size() - 1] = rows[r].res;
            end else begin
                send_point(rows[r].x, rows[r].y, rows[r].last);
            end
        end
        // store overflow, one dropped point
        for (int i = 0; i <= STORE_DEPTH; i++)
            send_point(16'($urandom), 16'($urandom), i == STORE_DEPTH);
        i_valid <= 1'b0;
        // hold off until everything has drained
        wait (fits_due.size() == 0);
        sent = 0;
        while (sent < 850) begin
            int n;
            if (sent > 300 && sent < 600) begin
                sender_idle_pct = 0; sink_idle_pct = 0;
            end else begin
                sender_idle_pct = 17; sink_idle_pct = 17;
            end
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
            send_set(n, ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 800),
                     $urandom_range(9) == 0);
            sent += n;
        end
        i_valid <= 1'b0;
        wait (fits_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (!failed && fits_due.size() == 0) begin
            $display("rectangle_edge_fit_core verification clean");
        end else begin
            $display("rectangle_edge_fit_core verification failed");
        end
        $finish;
    end
endmodule
